// File: rtl/fqrr_pkg.sv
// Shared types and constants for the FIFO queue with range reverse.
// Holds the payload structs, request and status codes, and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package fqrr_pkg;

   // Queue depth must stay a power of two so that slot arithmetic wraps for free.
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = 5;
   localparam int DATA_W      = 32;

   typedef enum logic [1:0] {
      REQ_PUSH    = 2'd0,
      REQ_POP     = 2'd1,
      REQ_REVERSE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SWAP_RD,
      S_SWAP_WA,
      S_SWAP_WB
   } state_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         range_start;
      logic [CNT_W-1:0]         range_end;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_data;
      logic [1:0]               status;
      logic [CNT_W-1:0]         fill_level;
      logic                     is_empty;
   } rsp_item_type;

   // Controller to output register: a finished result and its load strobe.
   typedef struct packed {
      logic         load;
      rsp_item_type item;
   } rsp_ctl_type;

   // Controller to entry memory.
   typedef struct packed {
      logic              we;
      logic [PTR_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [PTR_W-1:0]  raddr_a;
      logic [PTR_W-1:0]  raddr_b;
   } mem_ctl_type;

endpackage

// File: rtl/fqrr_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fqrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: rtl/fqrr_ctrl.sv
// Queue controller: head pointer, fill count, request decode and the swap sequencer.
// Depends on fqrr_pkg; drives the entry memory through fqrr_pkg::mem_ctl_type.
`timescale 1ns / 1ps

module fqrr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fqrr_pkg::req_item_type    req_data,
   input  logic                      rsp_free,
   input  logic [fqrr_pkg::DATA_W-1:0] rd_a,
   input  logic [fqrr_pkg::DATA_W-1:0] rd_b,
   output fqrr_pkg::mem_ctl_type     mem,
   output fqrr_pkg::rsp_ctl_type     res
);

   fqrr_pkg::state_type state_ff, state_in;
   logic [fqrr_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [fqrr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [fqrr_pkg::PTR_W-1:0]  lo_ff, lo_in;
   logic [fqrr_pkg::PTR_W-1:0]  hi_ff, hi_in;
   logic [fqrr_pkg::DATA_W-1:0] tmp_ff, tmp_in;

   logic                        fire;
   logic                        full;
   logic                        empty;
   logic                        bad_range;
   logic                        single;
   logic                        more_pairs;
   logic [fqrr_pkg::CNT_W-1:0]  rs_m1;
   logic [fqrr_pkg::CNT_W-1:0]  re_m1;
   logic [fqrr_pkg::PTR_W-1:0]  span;

   assign req_ready  = (state_ff == fqrr_pkg::S_IDLE) && rsp_free;
   assign fire       = req_valid && req_ready;
   assign full       = (count_ff == fqrr_pkg::CNT_W'(fqrr_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign bad_range  = (req_data.range_start == '0) ||
                       (req_data.range_start > req_data.range_end) ||
                       (req_data.range_end > count_ff);
   assign single     = (req_data.range_start == req_data.range_end);
   assign rs_m1      = req_data.range_start - fqrr_pkg::CNT_W'(1);
   assign re_m1      = req_data.range_end - fqrr_pkg::CNT_W'(1);
   assign span       = hi_ff - lo_ff;
   assign more_pairs = (span > fqrr_pkg::PTR_W'(2));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fqrr_pkg::S_IDLE: begin
            if (fire) begin
               if (req_data.req_type == fqrr_pkg::REQ_POP && !empty) begin
                  state_in = fqrr_pkg::S_POP;
               end else if (req_data.req_type == fqrr_pkg::REQ_REVERSE &&
                            !bad_range && !single) begin
                  state_in = fqrr_pkg::S_SWAP_RD;
               end
            end
         end
         fqrr_pkg::S_POP:     state_in = fqrr_pkg::S_IDLE;
         fqrr_pkg::S_SWAP_RD: state_in = fqrr_pkg::S_SWAP_WA;
         fqrr_pkg::S_SWAP_WA: state_in = fqrr_pkg::S_SWAP_WB;
         fqrr_pkg::S_SWAP_WB: state_in = more_pairs ? fqrr_pkg::S_SWAP_RD : fqrr_pkg::S_IDLE;
         default:             state_in = fqrr_pkg::S_IDLE;
      endcase
   end

   // Memory control, result and datapath register updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      tmp_in   = tmp_ff;

      mem.we      = 1'b0;
      mem.waddr   = head_ff + count_ff[fqrr_pkg::PTR_W-1:0];
      mem.wdata   = req_data.value;
      mem.raddr_a = head_ff;
      mem.raddr_b = head_ff;

      res.load            = 1'b0;
      res.item.pop_data   = '0;
      res.item.status     = fqrr_pkg::STAT_OK;
      res.item.fill_level = count_ff;
      res.item.is_empty   = empty;

      unique case (state_ff)
         fqrr_pkg::S_IDLE: begin
            if (fire) begin
               case (req_data.req_type)
                  fqrr_pkg::REQ_PUSH: begin
                     res.load = 1'b1;
                     if (full) begin
                        res.item.status = fqrr_pkg::STAT_OVER;
                     end else begin
                        mem.we              = 1'b1;
                        count_in            = count_ff + fqrr_pkg::CNT_W'(1);
                        res.item.fill_level = count_in;
                        res.item.is_empty   = 1'b0;
                     end
                  end
                  fqrr_pkg::REQ_POP: begin
                     // The head word arrives from memory next cycle.
                     if (empty) begin
                        res.load        = 1'b1;
                        res.item.status = fqrr_pkg::STAT_UNDER;
                     end else begin
                        head_in  = head_ff + fqrr_pkg::PTR_W'(1);
                        count_in = count_ff - fqrr_pkg::CNT_W'(1);
                     end
                  end
                  fqrr_pkg::REQ_REVERSE: begin
                     if (bad_range) begin
                        res.load        = 1'b1;
                        res.item.status = fqrr_pkg::STAT_RANGE;
                     end else if (single) begin
                        res.load = 1'b1;
                     end else begin
                        lo_in = rs_m1[fqrr_pkg::PTR_W-1:0];
                        hi_in = re_m1[fqrr_pkg::PTR_W-1:0];
                     end
                  end
                  default: begin
                     res.load = 1'b1;
                  end
               endcase
            end
         end
         fqrr_pkg::S_POP: begin
            res.load          = 1'b1;
            res.item.pop_data = rd_a;
         end
         fqrr_pkg::S_SWAP_RD: begin
            mem.raddr_a = head_ff + lo_ff;
            mem.raddr_b = head_ff + hi_ff;
         end
         fqrr_pkg::S_SWAP_WA: begin
            mem.we    = 1'b1;
            mem.waddr = head_ff + lo_ff;
            mem.wdata = rd_b;
            tmp_in    = rd_a;
         end
         fqrr_pkg::S_SWAP_WB: begin
            mem.we    = 1'b1;
            mem.waddr = head_ff + hi_ff;
            mem.wdata = tmp_ff;
            lo_in     = lo_ff + fqrr_pkg::PTR_W'(1);
            hi_in     = hi_ff - fqrr_pkg::PTR_W'(1);
            res.load  = !more_pairs;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqrr_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      tmp_ff <= tmp_in;
   end

   // The fill count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fqrr_pkg::CNT_W'(fqrr_pkg::QUEUE_DEPTH))
      else $error("fill count above queue depth");

   // While a swap is running the two cursors have not crossed.
   a_cursor_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fqrr_pkg::S_SWAP_RD || state_ff == fqrr_pkg::S_SWAP_WA ||
       state_ff == fqrr_pkg::S_SWAP_WB) |-> (lo_ff < hi_ff))
      else $error("swap cursors crossed");

   // A pop always finishes with a result in the cycle after acceptance.
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fqrr_pkg::S_POP) |-> (res.load && state_in == fqrr_pkg::S_IDLE))
      else $error("pop did not complete");

   // No request is taken while a pop or a swap is in flight.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fqrr_pkg::S_IDLE) |-> !req_ready)
      else $error("request accepted while busy");

   // The fill count does not change during a reverse.
   a_reverse_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fqrr_pkg::S_SWAP_WA) |=> $stable(count_ff))
      else $error("fill count changed during reverse");

endmodule

// File: rtl/fifo_queue_with_range_reverse.sv
// Top level of the FIFO queue with range reverse.
// Depends on fqrr_pkg, fqrr_ram and fqrr_ctrl.
`timescale 1ns / 1ps

// The block holds up to 16 signed 32-bit words in a circular store. Requests
// arrive on the req_ channel as one transfer each: push a word, pop the oldest
// word, or reverse the held entries between two positions counted from 1 at
// the head. Every request gives exactly one transfer on the rsp_ channel with
// the popped word, a status, the fill count after the request and an empty flag.
//
// Push, any rejected request and a one-entry reverse load their result into
// the output register in the cycle they are taken. A pop first passes through
// the pop state, since the head word comes from the registered read port of
// the entry memory. A reverse of n entries swaps floor(n/2) pairs, each in three
// steps (read both ends, write the low end, write the high end), since the entry
// memory has a single write port.
// One request is in progress at a time.
//
// Results sit in an output register. A new request is taken while a result
// waits, as long as that result is taken in the same cycle or the slot is
// empty. If the receiver stalls, the result holds and no new request is taken.
// Reset empties the queue and clears the result slot; the word contents are
// not cleared, since only entries written since then are ever read.

module fifo_queue_with_range_reverse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fqrr_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fqrr_pkg::rsp_item_type rsp_data
);

   fqrr_pkg::mem_ctl_type       mem;
   fqrr_pkg::rsp_ctl_type       res;
   logic [fqrr_pkg::DATA_W-1:0] rd_a;
   logic [fqrr_pkg::DATA_W-1:0] rd_b;
   logic                        rsp_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   fqrr_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // The result slot can accept a new result when it is empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fqrr_ram #(
      .WIDTH(fqrr_pkg::DATA_W),
      .DEPTH(fqrr_pkg::QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .we      (mem.we),
      .waddr   (mem.waddr),
      .wdata   (mem.wdata),
      .raddr_a (mem.raddr_a),
      .raddr_b (mem.raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   fqrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .mem       (mem),
      .res       (res)
   );

   // The controller only loads a result when the slot is free, so a load
   // always wins over a held result.
   always_comb begin
      rsp_valid_in = res.load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = res.load ? res.item : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: bench/fqrr_checker.sv
// Scoreboard for the FIFO queue with range reverse: predicts each result and checks it.
// Depends on fqrr_pkg for the payload structs and the request and status codes.
`timescale 1ns / 1ps

module fqrr_checker
   import fqrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   output int           fail_count,
   output int           pending_count,
   output int           held_level
);

   // Shadow copy of the queue: circular word store, head slot and fill count.
   logic [DATA_W-1:0] slot_word [QUEUE_DEPTH];
   int                head_slot = 0;
   int                held      = 0;
   int                fails     = 0;
   int                pending   = 0;
   rsp_item_type      awaited_q [$];

   assign fail_count    = fails;
   assign pending_count = pending;
   assign held_level    = held;

   function automatic int slot_at(int pos);
      return (head_slot + pos) % QUEUE_DEPTH;
   endfunction

   // Applies one request to the shadow queue and builds the result it must give.
   task automatic apply_request(input req_item_type r, output rsp_item_type o);
      int                lo;
      int                hi;
      logic [DATA_W-1:0] swap_word;
      o        = '0;
      o.status = STAT_OK;
      case (r.req_type)
         REQ_PUSH: begin
            if (held >= QUEUE_DEPTH) begin
               o.status = STAT_OVER;
            end else begin
               slot_word[slot_at(held)] = r.value;
               held++;
            end
         end
         REQ_POP: begin
            if (held == 0) begin
               o.status = STAT_UNDER;
            end else begin
               o.pop_data = slot_word[slot_at(0)];
               head_slot  = slot_at(1);
               held--;
            end
         end
         REQ_REVERSE: begin
            if (r.range_start == 0 || r.range_start > r.range_end || r.range_end > held) begin
               o.status = STAT_RANGE;
            end else begin
               lo = r.range_start - 1;
               hi = r.range_end - 1;
               while (lo < hi) begin
                  swap_word              = slot_word[slot_at(lo)];
                  slot_word[slot_at(lo)] = slot_word[slot_at(hi)];
                  slot_word[slot_at(hi)] = swap_word;
                  lo++;
                  hi--;
               end
            end
         end
         default: begin
         end
      endcase
      o.fill_level = CNT_W'(held);
      o.is_empty   = (held == 0);
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         head_slot = 0;
         held      = 0;
         awaited_q.delete();
      end else begin
         // A result can never belong to a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_q.size() == 0) begin
               $error("result transfer arrived with no request outstanding");
               fails++;
            end else begin
               want = awaited_q.pop_front();
               if (got.pop_data !== want.pop_data) begin
                  $error("pop_data: expected %0d, actual %0d", want.pop_data, got.pop_data);
                  fails++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fails++;
               end
               if (got.fill_level !== want.fill_level) begin
                  $error("fill_level: expected %0d, actual %0d",
                         want.fill_level, got.fill_level);
                  fails++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_data, want);
            awaited_q.push_back(want);
         end
      end
      pending = awaited_q.size();
   end

endmodule

// File: bench/fifo_queue_with_range_reverse_tb.sv
// Top of the testbench for the FIFO queue with range reverse.
// Depends on fqrr_pkg, the block fifo_queue_with_range_reverse and the checker fqrr_checker.
`timescale 1ns / 1ps

module fifo_queue_with_range_reverse_tb;
   import fqrr_pkg::*;

   // Request code 3 has no meaning; the block must answer it and change nothing.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Mix of requests used by each block of random transfers.
   localparam int MODE_FILL  = 0;
   localparam int MODE_SWAP  = 1;
   localparam int MODE_DRAIN = 2;
   localparam int MODE_MIXED = 3;

   localparam int RANDOM_ITEMS = 850;
   localparam int CHUNK_ITEMS  = 50;
   localparam int IDLE_PCT     = 24;
   // The longest legal silence is a full-depth reverse plus a receiver stall,
   // so this leaves a wide margin.
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;

   int           fail_count;
   int           pending_count;
   int           held_level;
   int           quiet_cycles;
   // While set, neither side inserts idle cycles.
   logic         steady;

   fifo_queue_with_range_reverse u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fqrr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .held_level    (held_level)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #4 clock = ~clock;
      end
   end

   // The receiver stalls at random in about a quarter of the cycles, except
   // during the steady stretch. It changes only at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: any cycle with a transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Offers one request, called at a falling edge. Random idle cycles come
   // first; then valid rises with the payload and both hold until the
   // transfer, which is seen at a rising edge. Returns at the next falling edge.
   task automatic send_request(input req_item_type item);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [1:0] code, input logic [DATA_W-1:0] word,
                              input int first, input int last);
      req_item_type item;
      item.req_type    = code;
      item.value       = word;
      item.range_start = CNT_W'(first);
      item.range_end   = CNT_W'(last);
      send_request(item);
   endtask

   // Builds one random request for the given mix. Most reverses are well formed
   // against the fill level the checker predicts, so that real swaps happen;
   // the rest carry arbitrary range fields, including the out-of-range codes.
   task automatic pick_request(input int mode, output req_item_type item);
      int push_pct;
      int pop_pct;
      int roll;
      int last;
      case (mode)
         MODE_FILL: begin
            push_pct = 70;
            pop_pct  = 15;
         end
         MODE_SWAP: begin
            push_pct = 35;
            pop_pct  = 20;
         end
         MODE_DRAIN: begin
            push_pct = 20;
            pop_pct  = 70;
         end
         MODE_MIXED: begin
            push_pct = 40;
            pop_pct  = 35;
         end
         default: begin
            push_pct = 40;
            pop_pct  = 35;
         end
      endcase
      item.range_start = CNT_W'($urandom_range(0, 31));
      item.range_end   = CNT_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0:       item.value = {1'b1, {(DATA_W-1){1'b0}}};
         1:       item.value = {1'b0, {(DATA_W-1){1'b1}}};
         2:       item.value = '0;
         3:       item.value = '1;
         default: item.value = $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         item.req_type = REQ_UNUSED;
      end else if (roll < push_pct) begin
         item.req_type = REQ_PUSH;
      end else if (roll < push_pct + pop_pct) begin
         item.req_type = REQ_POP;
      end else begin
         item.req_type = REQ_REVERSE;
         if (held_level > 0 && $urandom_range(0, 99) < 80) begin
            last             = $urandom_range(1, held_level);
            item.range_end   = CNT_W'(last);
            item.range_start = CNT_W'($urandom_range(1, last));
         end
      end
   endtask

   initial begin : stimulus
      req_item_type item;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      steady    = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Empty-queue cases come first: pop underflow, a reverse
      // beyond the fill count, and the unused request code.
      send_fields(REQ_POP, '0, 0, 0);
      send_fields(REQ_REVERSE, '0, 1, 1);
      send_fields(REQ_UNUSED, '1, 31, 31);
      // Extreme words, then reverses on five held entries.
      send_fields(REQ_PUSH, {1'b1, {(DATA_W-1){1'b0}}}, 0, 0);
      send_fields(REQ_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, 0, 0);
      send_fields(REQ_PUSH, '1, 0, 0);
      send_fields(REQ_PUSH, 32'h5555_5555, 16, 16);
      send_fields(REQ_PUSH, 32'hAAAA_AAAA, 31, 0);
      send_fields(REQ_REVERSE, '0, 1, 5);
      send_fields(REQ_REVERSE, '0, 2, 3);
      send_fields(REQ_REVERSE, '0, 3, 3);
      // Bad ranges: zero start, inverted, past the fill count, top codes.
      send_fields(REQ_REVERSE, '0, 0, 2);
      send_fields(REQ_REVERSE, '0, 4, 2);
      send_fields(REQ_REVERSE, '0, 1, 6);
      send_fields(REQ_REVERSE, '0, 16, 16);
      send_fields(REQ_REVERSE, '0, 31, 31);
      send_fields(REQ_UNUSED, 32'h1234_5678, 1, 5);
      send_fields(REQ_POP, '1, 31, 31);
      send_fields(REQ_REVERSE, '0, 1, 4);
      send_fields(REQ_POP, '0, 0, 0);
      send_fields(REQ_POP, '0, 0, 0);
      send_fields(REQ_POP, '0, 0, 0);
      send_fields(REQ_POP, '0, 0, 0);
      send_fields(REQ_POP, '0, 0, 0);

      // Random part in blocks that alternate the request mix, so the queue
      // fills to overflow, gets reversed while full and drains to underflow.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 400);
         pick_request((n / CHUNK_ITEMS) % 4, item);
         send_request(item);
      end
      steady    = 1'b0;
      req_valid <= 1'b0;

      // Wait for every outstanding result, then a little longer so that a
      // stray extra result would still be caught by the checker.
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
